// ===== rtl/core/tzt_pkg.sv =====
// Package for the threshold zone tracker: word types, zone and event codes,
// register indexes and queue sizing. Depends on nothing; every other file uses it.
`timescale 1ns / 1ps
`default_nettype none

package tzt_pkg;

    // Zones, lowest to highest.
    localparam logic [2:0] ZONE_LNR  = 3'd0;
    localparam logic [2:0] ZONE_LC   = 3'd1;
    localparam logic [2:0] ZONE_LNC  = 3'd2;
    localparam logic [2:0] ZONE_NORM = 3'd3;
    localparam logic [2:0] ZONE_UNC  = 3'd4;
    localparam logic [2:0] ZONE_UC   = 3'd5;
    localparam logic [2:0] ZONE_UNR  = 3'd6;

    // Event codes.
    localparam logic [3:0] EV_LNR_UP   = 4'd0;
    localparam logic [3:0] EV_LNR_DOWN = 4'd1;
    localparam logic [3:0] EV_LC_UP    = 4'd2;
    localparam logic [3:0] EV_LC_DOWN  = 4'd3;
    localparam logic [3:0] EV_LNC_UP   = 4'd4;
    localparam logic [3:0] EV_LNC_DOWN = 4'd5;
    localparam logic [3:0] EV_UNC_UP   = 4'd6;
    localparam logic [3:0] EV_UNC_DOWN = 4'd7;
    localparam logic [3:0] EV_UC_UP    = 4'd8;
    localparam logic [3:0] EV_UC_DOWN  = 4'd9;
    localparam logic [3:0] EV_UNR_UP   = 4'd10;
    localparam logic [3:0] EV_UNR_DOWN = 4'd11;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] REG_UNR = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_UC  = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_UNC = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LNR = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LC  = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_LNC = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_FH  = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_RH  = 4'd7;

    // Queue between the classifier and the event emitter.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] sensor_tag;
        logic [7:0] sample_value;
    } in_word_t;

    typedef struct packed {
        logic [7:0] event_tag;
        logic [3:0] event_code;
        logic [2:0] zone_after;
        logic       last_event;
    } out_word_t;

    typedef struct packed {
        logic [7:0] upper_nonrecoverable;
        logic [7:0] upper_critical;
        logic [7:0] upper_noncritical;
        logic [7:0] lower_nonrecoverable;
        logic [7:0] lower_critical;
        logic [7:0] lower_noncritical;
        logic [7:0] falling_hysteresis;
        logic [7:0] rising_hysteresis;
    } cfg_t;

    // One classified sample: one or two events for the same tag.
    typedef struct packed {
        logic [7:0] tag;
        logic       two_events;
        logic [3:0] code0;
        logic [2:0] zone0;
        logic [3:0] code1;
        logic [2:0] zone1;
    } rec_t;

    // Queue status seen by the front and back.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/tzt_cfg.sv =====
// Threshold and hysteresis registers of the zone tracker.
// Depends on tzt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tzt_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             wr_en,
    input  wire logic [tzt_pkg::CFG_INDEX_W-1:0]  wr_index,
    input  wire logic [7:0]                       wr_data,
    output tzt_pkg::cfg_t                         cfg
);

    tzt_pkg::cfg_t cfg_reg;
    tzt_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                tzt_pkg::REG_UNR: cfg_next.upper_nonrecoverable = wr_data;
                tzt_pkg::REG_UC:  cfg_next.upper_critical       = wr_data;
                tzt_pkg::REG_UNC: cfg_next.upper_noncritical    = wr_data;
                tzt_pkg::REG_LNR: cfg_next.lower_nonrecoverable = wr_data;
                tzt_pkg::REG_LC:  cfg_next.lower_critical       = wr_data;
                tzt_pkg::REG_LNC: cfg_next.lower_noncritical    = wr_data;
                tzt_pkg::REG_FH:  cfg_next.falling_hysteresis   = wr_data;
                tzt_pkg::REG_RH:  cfg_next.rising_hysteresis    = wr_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.upper_nonrecoverable <= 8'd255;
            cfg_reg.upper_critical       <= 8'd255;
            cfg_reg.upper_noncritical    <= 8'd255;
            cfg_reg.lower_nonrecoverable <= 8'd0;
            cfg_reg.lower_critical       <= 8'd0;
            cfg_reg.lower_noncritical    <= 8'd0;
            cfg_reg.falling_hysteresis   <= 8'd0;
            cfg_reg.rising_hysteresis    <= 8'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tzt_front.sv =====
// Classifier: holds the current zone, compares each accepted sample with the
// thresholds next to it and pushes a record of the resulting events. Depends on tzt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tzt_front (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire tzt_pkg::in_word_t       sample,
    input  wire tzt_pkg::cfg_t           cfg,
    input  wire tzt_pkg::q_status_t      q_status,
    output logic                         q_wr_en,
    output tzt_pkg::rec_t                q_wr_data
);

    logic [2:0] zone_reg;
    logic [2:0] zone_next;

    logic       accept;
    logic [8:0] s9;
    logic [8:0] lnr_rh;
    logic [8:0] lc_rh;
    logic [8:0] lnc_rh;
    logic [8:0] s_fh;
    logic       hit_a;
    logic       hit_b;
    logic [3:0] code_a;
    logic [2:0] zone_a;
    logic [3:0] code_b;
    logic [2:0] zone_b;

    assign accept = push && !q_status.full;

    // Sums stay exact in 9 bits; "s < t - fh" is tested as "s + fh < t".
    assign s9     = {1'b0, sample.sample_value};
    assign lnr_rh = {1'b0, cfg.lower_nonrecoverable} + {1'b0, cfg.rising_hysteresis};
    assign lc_rh  = {1'b0, cfg.lower_critical} + {1'b0, cfg.rising_hysteresis};
    assign lnc_rh = {1'b0, cfg.lower_noncritical} + {1'b0, cfg.rising_hysteresis};
    assign s_fh   = s9 + {1'b0, cfg.falling_hysteresis};

    // Two tests per zone, a before b; zones at either end have only test b.
    always_comb
    begin
        hit_a  = 1'b0;
        hit_b  = 1'b0;
        code_a = tzt_pkg::EV_LNR_DOWN;
        zone_a = tzt_pkg::ZONE_LNR;
        code_b = tzt_pkg::EV_LNR_UP;
        zone_b = tzt_pkg::ZONE_LC;
        case (zone_reg)
            tzt_pkg::ZONE_LNR:
            begin
                hit_b  = s9 > lnr_rh;
                code_b = tzt_pkg::EV_LNR_UP;
                zone_b = tzt_pkg::ZONE_LC;
            end
            tzt_pkg::ZONE_LC:
            begin
                hit_a  = sample.sample_value <= cfg.lower_nonrecoverable;
                code_a = tzt_pkg::EV_LNR_DOWN;
                zone_a = tzt_pkg::ZONE_LNR;
                hit_b  = s9 > lc_rh;
                code_b = tzt_pkg::EV_LC_UP;
                zone_b = tzt_pkg::ZONE_LNC;
            end
            tzt_pkg::ZONE_LNC:
            begin
                hit_a  = sample.sample_value <= cfg.lower_critical;
                code_a = tzt_pkg::EV_LC_DOWN;
                zone_a = tzt_pkg::ZONE_LC;
                hit_b  = s9 > lnc_rh;
                code_b = tzt_pkg::EV_LNC_UP;
                zone_b = tzt_pkg::ZONE_NORM;
            end
            tzt_pkg::ZONE_NORM:
            begin
                hit_a  = sample.sample_value <= cfg.lower_noncritical;
                code_a = tzt_pkg::EV_LNC_DOWN;
                zone_a = tzt_pkg::ZONE_LNC;
                hit_b  = sample.sample_value >= cfg.upper_noncritical;
                code_b = tzt_pkg::EV_UNC_UP;
                zone_b = tzt_pkg::ZONE_UNC;
            end
            tzt_pkg::ZONE_UNC:
            begin
                hit_a  = sample.sample_value >= cfg.upper_critical;
                code_a = tzt_pkg::EV_UC_UP;
                zone_a = tzt_pkg::ZONE_UC;
                hit_b  = s_fh < {1'b0, cfg.upper_noncritical};
                code_b = tzt_pkg::EV_UNC_DOWN;
                zone_b = tzt_pkg::ZONE_NORM;
            end
            tzt_pkg::ZONE_UC:
            begin
                hit_a  = sample.sample_value >= cfg.upper_nonrecoverable;
                code_a = tzt_pkg::EV_UNR_UP;
                zone_a = tzt_pkg::ZONE_UNR;
                hit_b  = s_fh < {1'b0, cfg.upper_critical};
                code_b = tzt_pkg::EV_UC_DOWN;
                zone_b = tzt_pkg::ZONE_UNC;
            end
            tzt_pkg::ZONE_UNR:
            begin
                hit_b  = s_fh < {1'b0, cfg.upper_nonrecoverable};
                code_b = tzt_pkg::EV_UNR_DOWN;
                zone_b = tzt_pkg::ZONE_UC;
            end
            default:
            begin
                hit_a = 1'b0;
                hit_b = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        q_wr_data.tag        = sample.sensor_tag;
        q_wr_data.two_events = hit_a && hit_b;
        q_wr_data.code0      = hit_a ? code_a : code_b;
        q_wr_data.zone0      = hit_a ? zone_a : zone_b;
        q_wr_data.code1      = code_b;
        q_wr_data.zone1      = zone_b;
        q_wr_en              = accept && (hit_a || hit_b);

        zone_next = zone_reg;
        if (accept)
        begin
            if (hit_b)
            begin
                zone_next = zone_b;
            end
            else if (hit_a)
            begin
                zone_next = zone_a;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg <= tzt_pkg::ZONE_NORM;
        end
        else
        begin
            zone_reg <= zone_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tzt_queue.sv =====
// Short register queue of classified records between classifier and emitter.
// Depends on tzt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tzt_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire tzt_pkg::rec_t  wr_data,
    input  wire logic           rd_en,
    output tzt_pkg::rec_t       rd_data,
    output tzt_pkg::q_status_t  status
);

    tzt_pkg::rec_t                 slot_reg [tzt_pkg::QUEUE_DEPTH];
    logic [tzt_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [tzt_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [tzt_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [tzt_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [tzt_pkg::QPTR_W:0]      count_reg;
    logic [tzt_pkg::QPTR_W:0]      count_next;

    localparam logic [tzt_pkg::QPTR_W:0] FULL_COUNT =
        (tzt_pkg::QPTR_W + 1)'(tzt_pkg::QUEUE_DEPTH);
    localparam logic [tzt_pkg::QPTR_W-1:0] PTR_ONE = (tzt_pkg::QPTR_W)'(1);
    localparam logic [tzt_pkg::QPTR_W:0] CNT_ONE = (tzt_pkg::QPTR_W + 1)'(1);

    assign status.full  = count_reg == FULL_COUNT;
    assign status.empty = count_reg == '0;
    assign rd_data      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + PTR_ONE : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + PTR_ONE : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + CNT_ONE;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    // The classifier only writes when it saw room.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !status.full)
        else $error("queue written while full");
    // The emitter only pops a record that is there.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !status.empty)
        else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/tzt_back.sv =====
// Event emitter: expands each queued record into one or two result words
// held in an output register. Depends on tzt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tzt_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tzt_pkg::rec_t       head,
    input  wire tzt_pkg::q_status_t  q_status,
    output logic                     q_rd_en,
    input  wire logic                pop,
    output logic                     empty,
    output tzt_pkg::out_word_t       result
);

    logic                valid_reg;
    logic                valid_next;
    logic                phase_reg;
    logic                phase_next;
    tzt_pkg::out_word_t  word_reg;
    tzt_pkg::out_word_t  word_next;
    logic                load;
    logic                is_last;

    // The output register takes a new word when it is free or being drained.
    assign load    = !q_status.empty && (!valid_reg || pop);
    assign is_last = !head.two_events || phase_reg;
    assign q_rd_en = load && is_last;

    always_comb
    begin
        word_next.event_tag  = head.tag;
        word_next.event_code = phase_reg ? head.code1 : head.code0;
        word_next.zone_after = phase_reg ? head.zone1 : head.zone0;
        word_next.last_event = is_last;

        valid_next = valid_reg;
        phase_next = phase_reg;
        if (load)
        begin
            valid_next = 1'b1;
            phase_next = !is_last;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    assign empty  = !valid_reg;
    assign result = word_reg;

`ifndef ASSERT_OFF
    // Halfway through a record, that record is still at the queue head.
    a_phase_head: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (!q_status.empty && head.two_events))
        else $error("second event pending without a two-event record");
    // A word that is not the last of its sample is followed by its partner.
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !is_last) |=> (phase_reg && valid_reg))
        else $error("first of two events not followed by its partner");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/threshold_zone_tracker_core.sv =====
// Top level of the threshold zone tracker: configuration registers,
// classifier, record queue and event emitter. Depends on tzt_pkg and all tzt_* modules.
// A sample's first event word passes through the record queue, then the output register.
// One sample per cycle while full is low; a two-event sample yields two words in turn.
// Both rest on the single output register and the 4-record queue.
// Reset (rst_n low, asynchronous): zone normal, thresholds at their reset values, all empty.
`timescale 1ns / 1ps
`default_nettype none

module threshold_zone_tracker_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Sample side: a word is taken when push is high and full is low.
    input  wire logic                             push,
    output logic                                  full,
    input  wire tzt_pkg::in_word_t                sample,
    // Event side: the oldest event word is shown while empty is low.
    output logic                                  empty,
    input  wire logic                             pop,
    output tzt_pkg::out_word_t                    result,
    // Configuration write channel; always ready.
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [tzt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [7:0]                       cfg_data
);

    tzt_pkg::cfg_t       cfg;
    tzt_pkg::q_status_t  q_status;
    tzt_pkg::rec_t       q_wr_data;
    tzt_pkg::rec_t       q_head;
    logic                q_wr_en;
    logic                q_rd_en;

    // Configuration must only be written while the block is idle, so that a write
    // never races a sample in flight; the block does not enforce this. The port is always ready.
    assign cfg_ready = 1'b1;

    tzt_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // The classifier owns the zone register and updates it in the cycle the
    // sample is accepted, so the next sample may follow directly. Samples
    // that cross nothing produce no record.
    tzt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .sample    (sample),
        .cfg       (cfg),
        .q_status  (q_status),
        .q_wr_en   (q_wr_en),
        .q_wr_data (q_wr_data)
    );

    // The queue decouples the classifier from a stalled event consumer.
    tzt_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr_en),
        .wr_data (q_wr_data),
        .rd_en   (q_rd_en),
        .rd_data (q_head),
        .status  (q_status)
    );

    // The emitter walks each record one event word at a time.
    tzt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .q_status (q_status),
        .q_rd_en  (q_rd_en),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

    assign full = q_status.full;

`ifndef ASSERT_OFF
    // A word just shown to the consumer and not taken is still there next cycle.
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("event word changed before it was taken");
`endif

endmodule

`default_nettype wire
